// ===== hdl/mdg_pkg.sv =====
// Shared types and constants of the 3x3 maximum directional gradient unit.
package mdg_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int PIXEL_BITS = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 15;
    localparam int FW_W       = 12;
    localparam int OUT_COL_W  = 11;
    localparam int CFG_DATA_W = 15;
    localparam int DATA_BITS  = PIXEL_BITS + ROW_W + OUT_COL_W + PIXEL_BITS;
    localparam int TDATA_W    = ((DATA_BITS + 7) / 8) * 8;
    localparam int IN_DATA_W  = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int NUM_SLOTS  = 4;

    // Register indexes on the configuration channel
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef pix_t [2:0] pix_col_t;   // [0] row r-2, [1] row r-1, [2] row r

    typedef struct packed {
        pix_t             pixel;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             first;
        logic             last_col;
        logic             last_row;
    } s1_t;

    typedef struct packed {
        pix_t                 intensity;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        pix_t                 peak;
        logic                 done;
    } res_t;

    typedef res_t [NUM_SLOTS-1:0] res_bundle_t;

endpackage

// ===== hdl/mdg_calc.sv =====
// Gradient terms, result slots and running peak for one pixel's window.
module mdg_calc
    import mdg_pkg::*;
(
    input  s1_t                  info,
    input  pix_col_t             win_a,
    input  pix_col_t             win_b,
    input  pix_col_t             win_n,
    input  pix_t                 peak_in,
    output res_bundle_t          slots,
    output logic [NUM_SLOTS-1:0] mask,
    output pix_t                 peak_out
);

    function automatic pix_t absd(input pix_t a, input pix_t b);
        return (a > b) ? pix_t'(a - b) : pix_t'(b - a);
    endfunction

    function automatic pix_t pmax(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    pix_t val0;
    pix_t val1;
    pix_t val2;
    pix_t run;
    pix_t vals [NUM_SLOTS];
    logic [ROW_W-1:0] row_up;
    logic [COL_W-1:0] col_lf;

    assign r_ge1  = (info.row != '0);
    assign r_ge2  = (info.row[ROW_W-1:1] != '0);
    assign c_ge1  = (info.col != '0);
    assign c_ge2  = (info.col[COL_W-1:1] != '0);
    assign row_up = info.row - ROW_W'(1);
    assign col_lf = info.col - COL_W'(1);

    always_comb
    begin
        // centre one row up, one column left: all four terms may apply
        val0 = '0;
        if (r_ge2 && c_ge2)
        begin
            val0 = pmax(val0, absd(win_a[0], win_n[2]));
            val0 = pmax(val0, absd(win_n[0], win_a[2]));
        end
        if (r_ge2)
            val0 = pmax(val0, absd(win_b[0], win_b[2]));
        if (c_ge2)
            val0 = pmax(val0, absd(win_a[1], win_n[1]));
        // last column, row above: vertical only
        val1 = r_ge2 ? absd(win_n[0], win_n[2]) : '0;
        // last row, column left: horizontal only
        val2 = c_ge2 ? absd(win_a[2], win_n[2]) : '0;
    end

    assign mask[0] = r_ge1 && c_ge1;
    assign mask[1] = r_ge1 && info.last_col;
    assign mask[2] = info.last_row && c_ge1;
    assign mask[3] = info.last_row && info.last_col;

    assign vals[0] = val0;
    assign vals[1] = val1;
    assign vals[2] = val2;
    assign vals[3] = '0;

    always_comb
    begin
        run = info.first ? pix_t'(0) : peak_in;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (mask[k])
                run = pmax(run, vals[k]);
            slots[k].intensity = vals[k];
            slots[k].peak      = run;
        end
        peak_out = run;

        slots[0].row  = row_up;
        slots[0].col  = OUT_COL_W'(col_lf);
        slots[0].done = 1'b0;
        slots[1].row  = row_up;
        slots[1].col  = OUT_COL_W'(info.col);
        slots[1].done = 1'b0;
        slots[2].row  = info.row;
        slots[2].col  = OUT_COL_W'(col_lf);
        slots[2].done = 1'b0;
        slots[3].row  = info.row;
        slots[3].col  = OUT_COL_W'(info.col);
        slots[3].done = 1'b1;
    end

endmodule

// ===== hdl/max_directional_gradient_3x3_unit.sv =====
// Top level of the streaming 3x3 maximum directional gradient unit.
//
// Takes grey pixels in raster order, one per clock, and gives for each pixel the
// largest absolute difference across its 3x3 neighbourhood (diagonals, vertical pair,
// horizontal pair; a term whose neighbours fall outside the frame counts as zero),
// together with its row, column and the running peak of the frame. Results follow
// once their window's last in-frame pixel (below-right, off the edges) has arrived, in
// raster order, but the last row's results interleave with the row above's. A pixel
// that is not in the first row or column yields one result, so the sustained rate is
// one pixel per clock while m_tready is high; the last pixel of a later row yields
// two, every later pixel of the last row yields two and the frame's last pixel up to
// four, so the input is held off there while the extra results leave. The two previous
// rows sit in one line store (MAX_WIDTH words of two pixels) with one read and one
// write port; the read is issued on the pixel transfer and the write-back happens when
// the pixel leaves stage 1, with forwarding when a one-pixel-wide frame reads the
// entry that is being written. A pixel waits in stage 1, its results in the result
// slots. The line store is not cleared after reset; no result depends on an entry not
// written in the current frame. frame_start on s_tuser restarts the position and the
// peak; after a frame's last pixel the position wraps on its own. Write frame_width
// (index 0) and frame_height (index 1) only while no results are outstanding.
module max_directional_gradient_3x3_unit
    import mdg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // pixel
    input  logic                  s_tuser,   // frame_start
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // intensity, out_row, out_col, frame_peak
    output logic                  m_tlast,   // last_of_run
    output logic                  m_tuser    // frame_done
);

    localparam int MEM_W = 2 * PIXEL_BITS;

    // configuration
    logic [FW_W-1:0]  frame_width_reg;
    logic [ROW_W-1:0] frame_height_reg;

    // position counters
    logic [COL_W-1:0] column_count_reg;
    logic [COL_W-1:0] column_count_next;
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;

    // stage 1: pixel waiting for its line store read
    logic             s1_valid_reg;
    s1_t              s1_reg;
    s1_t              s1_next;

    // line store and forwarding
    logic [MEM_W-1:0] line_mem [MAX_WIDTH];
    logic [MEM_W-1:0] rd_data_reg;
    logic [MEM_W-1:0] fwd_data_reg;
    logic             fwd_reg;
    logic [MEM_W-1:0] line_word;
    logic [MEM_W-1:0] wr_word;

    // window columns: a = two columns back, b = one back, n = arriving column
    pix_col_t         win_a_reg;
    pix_col_t         win_b_reg;
    pix_col_t         win_n;

    pix_t             peak_reg;
    pix_t             peak_calc;

    // stage 2: result slots awaiting transfer
    res_bundle_t          bundle_reg;
    res_bundle_t          bundle_calc;
    logic [NUM_SLOTS-1:0] pend_reg;
    logic [NUM_SLOTS-1:0] pend_next;
    logic [NUM_SLOTS-1:0] mask_calc;
    logic [1:0]           sel;
    res_t                 res_sel;

    logic             accept;
    logic             s1_adv;
    logic             single;
    logic             out_xfer;
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic [COL_W-1:0] col_base;
    logic [ROW_W-1:0] row_base;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_W'(640);
            frame_height_reg <= ROW_W'(480);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[ROW_W-1:0];
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // --------------------------------------------------------- handshakes
    assign single   = ((pend_reg & (pend_reg - NUM_SLOTS'(1))) == '0);
    assign m_tvalid = (pend_reg != '0);
    assign out_xfer = m_tvalid && m_tready;
    // stage 1 moves on when the slots are empty or their last result leaves now
    assign s1_adv   = s1_valid_reg && (!m_tvalid || (m_tready && single));
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // ------------------------------------------------- position of new pixel
    always_comb
    begin
        // clamp the frame size: width zero acts as one, wide frames saturate
        if (frame_width_reg == '0)
            wm1 = '0;
        else if (32'(frame_width_reg) > MAX_WIDTH)
            wm1 = COL_W'(MAX_WIDTH - 1);
        else
            wm1 = COL_W'(frame_width_reg - FW_W'(1));
        hm1 = (frame_height_reg == '0) ? '0 : frame_height_reg - ROW_W'(1);

        col_base = s_tuser ? '0 : column_count_reg;
        row_base = s_tuser ? '0 : row_count_reg;
        col_cur  = (col_base > wm1) ? wm1 : col_base;
        row_cur  = (row_base > hm1) ? hm1 : row_base;

        s1_next.pixel    = s_tdata[PIXEL_BITS-1:0];
        s1_next.row      = row_cur;
        s1_next.col      = col_cur;
        s1_next.first    = s_tuser;
        s1_next.last_col = (col_cur == wm1);
        s1_next.last_row = (row_cur == hm1);

        if (s1_next.last_col)
        begin
            column_count_next = '0;
            row_count_next    = s1_next.last_row ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            column_count_next = col_cur + COL_W'(1);
            row_count_next    = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_reg          <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
                // same entry read while the previous pixel writes it back
                fwd_reg          <= s1_adv && (col_cur == s1_reg.col);
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg       <= s1_next;
            fwd_data_reg <= wr_word;
        end
    end

    // ------------------------------------------------------------ line store
    // word = {row r-2, row r-1} for one column
    assign line_word = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign wr_word   = {line_word[PIXEL_BITS-1:0], s1_reg.pixel};
    assign win_n[0]  = line_word[MEM_W-1:PIXEL_BITS];
    assign win_n[1]  = line_word[PIXEL_BITS-1:0];
    assign win_n[2]  = s1_reg.pixel;

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= line_mem[col_cur];
        if (s1_adv)
            line_mem[s1_reg.col] <= wr_word;
    end

    // ------------------------------------------------ window and results
    mdg_calc u_calc (
        .info     (s1_reg),
        .win_a    (win_a_reg),
        .win_b    (win_b_reg),
        .win_n    (win_n),
        .peak_in  (peak_reg),
        .slots    (bundle_calc),
        .mask     (mask_calc),
        .peak_out (peak_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_a_reg <= '0;
            win_b_reg <= '0;
            peak_reg  <= '0;
        end
        else if (s1_adv)
        begin
            win_a_reg <= win_b_reg;
            win_b_reg <= win_n;
            // drop the peak once the frame's last pixel is through
            peak_reg  <= (s1_reg.last_col && s1_reg.last_row) ? pix_t'(0) : peak_calc;
        end
    end

    // ------------------------------------------------------- output slots
    always_comb
    begin
        sel = 2'd0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--)
        begin
            if (pend_reg[k])
                sel = 2'(k);
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (out_xfer)
            pend_next = pend_reg & ~(NUM_SLOTS'(1) << sel);
        if (s1_adv)
            pend_next = mask_calc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            bundle_reg <= bundle_calc;
    end

    assign res_sel = bundle_reg[sel];
    assign m_tdata = TDATA_W'({res_sel.peak, res_sel.col, res_sel.row, res_sel.intensity});
    assign m_tlast = single;
    assign m_tuser = res_sel.done;

`ifndef SYNTHESIS
    // the frame's final result always closes the run of its pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_done result not marked last of run");

    // the running peak never falls below the result it travels with
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_sel.peak >= res_sel.intensity))
        else $error("frame peak below intensity");

    // a transferred pixel occupies stage 1 on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel lost before line store read");

    // back-to-back pixels share a column only at column zero
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> (s1_reg.col == '0))
        else $error("forward taken away from column zero");
`endif

endmodule
